>>> hdl/ssid_pkg.sv
// ---------------------------------------------------------------------------
// ssid_pkg
// Types and codes shared by the sorted set store and its storage cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ssid_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

   // operation codes of an input item
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   // commands broadcast to every cell
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_HOLD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CMP  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROT  = 3'd4;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      has_entry;
      logic signed [VALUE_W-1:0] entry_value;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                      lt;
      logic signed [VALUE_W-1:0] entry;
   } cell_link_type;

endpackage

`default_nettype wire

>>> hdl/ssid_cell.sv
// ---------------------------------------------------------------------------
// ssid_cell
// One storage slot of the sorted chain: compares its entry against the
// broadcast value and shifts entries to or from its neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module ssid_cell
   import ssid_pkg::*;
(
   input  wire logic                      clock,
   input  wire cell_ctl_type              ctl,
   input  wire logic                      occupied,
   input  wire logic                      tail,
   input  wire cell_link_type             left,
   input  wire logic signed [VALUE_W-1:0] right_entry,
   input  wire logic signed [VALUE_W-1:0] head_entry,
   output      cell_link_type             link,
   output      logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      unique case (ctl.cmd)
         CMD_CMP: begin
            lt_in = occupied && (entry_ff < ctl.value);
            eq_in = occupied && (entry_ff == ctl.value);
         end
         CMD_INS: begin
            // entries at or above the new value move up by one
            if (!lt_ff) begin
               entry_in = left.lt ? ctl.value : left.entry;
            end
         end
         CMD_DEL: begin
            if (!lt_ff) begin
               entry_in = right_entry;
            end
         end
         CMD_ROT: begin
            entry_in = tail ? head_entry : right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign link.lt    = lt_ff;
   assign link.entry = entry_ff;
   assign eq         = eq_ff;

endmodule

`default_nettype wire

>>> hdl/sorted_set_insert_delete.sv
// ---------------------------------------------------------------------------
// sorted_set_insert_delete
// Sorted set of distinct signed 32-bit values kept in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one item per operation, kind 0 inserts value, kind 1
//   deletes it. req_stall is high while an operation is in progress.
//   rsp channel: results with status; a successful insert dumps the whole
//   list in ascending order, one entry per result, last set on the final
//   one. Every other outcome gives one result with last set.
// Sequence:
//   Accept step (S_IDLE), compare step (S_CMP), decision step (S_EXEC);
//   the decision step loads a single-result item's result into the
//   output register. A successful insert then rotates the chain once per
//   emitted entry in S_DUMP, up to CAPACITY entries.
//   The next item is accepted once the last result has been loaded into
//   the output register.
// Reset clears the entry count and the control state; stored values need
// no clearing. A stall on rsp holds the output register and freezes the
// decision or dump step until the result can be loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_set_insert_delete
   import ssid_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_DUMP = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          dump_ff, dump_in;
   logic                      kind_ff, kind_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   cell_ctl_type              ctl;
   cell_link_type             links [CAPACITY];
   logic [CAPACITY-1:0]       eqs;
   logic signed [VALUE_W-1:0] head;

   logic accept, out_load, emit, dump_last;
   rsp_type emit_data;

   assign head      = links[0].entry;
   assign accept    = req_valid && !req_stall;
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign dump_last = (dump_ff == count_ff - CNT_W'(1));
   assign req_stall = (state_ff != S_IDLE);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         cell_link_type             left;
         logic signed [VALUE_W-1:0] right_entry;
         if (gi == 0) begin : g_first
            assign left.lt    = 1'b1;
            assign left.entry = '0;
         end else begin : g_mid
            assign left = links[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_lastc
            assign right_entry = '0;
         end else begin : g_right
            assign right_entry = links[gi+1].entry;
         end
         ssid_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (CNT_W'(gi) < count_ff),
            .tail        (CNT_W'(gi + 1) == count_ff),
            .left        (left),
            .right_entry (right_entry),
            .head_entry  (head),
            .link        (links[gi]),
            .eq          (eqs[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      dump_in   = dump_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      ctl.cmd   = CMD_HOLD;
      ctl.value = value_ff;
      emit      = 1'b0;
      emit_data = '{status: ST_INSERTED, has_entry: 1'b0, entry_value: '0, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_data.kind;
               value_in = req_data.value;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctl.cmd  = CMD_CMP;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_load) begin
               state_in = S_IDLE;
               if (kind_ff == KIND_INSERT) begin
                  priority if (|eqs) begin
                     emit             = 1'b1;
                     emit_data.status = ST_DUPLICATE;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     emit             = 1'b1;
                     emit_data.status = ST_FULL;
                  end else begin
                     ctl.cmd  = CMD_INS;
                     count_in = count_ff + CNT_W'(1);
                     dump_in  = '0;
                     state_in = S_DUMP;
                  end
               end else begin
                  emit = 1'b1;
                  priority if (count_ff == '0) begin
                     emit_data.status = ST_EMPTY;
                  end else if (!(|eqs)) begin
                     emit_data.status = ST_NOT_FOUND;
                  end else begin
                     emit_data.status = ST_DELETED;
                     ctl.cmd          = CMD_DEL;
                     count_in         = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         S_DUMP: begin
            if (out_load) begin
               // head of the chain goes out, the list rotates left by one
               emit                  = 1'b1;
               emit_data.status      = ST_INSERTED;
               emit_data.has_entry   = 1'b1;
               emit_data.entry_value = head;
               emit_data.last        = dump_last;
               ctl.cmd               = CMD_ROT;
               dump_in               = dump_ff + CNT_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = emit;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dump_ff     <= dump_in;
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CMP)
      else $error("accepted item did not start compare");

   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP && emit && dump_last) |=> state_ff == S_IDLE)
      else $error("dump did not end after last entry");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_DEL) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shrink the count");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives insert and delete operations into the sorted set store and checks
// every result. A queue-based copy of the set is updated on each accepted
// operation, and the list dump or status that the operation should produce
// is queued. Each result handed over on rsp is compared with the oldest entry.
// ---------------------------------------------------------------------------

module tb_top;
   import ssid_pkg::*;

   localparam int SET_CAPACITY  = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = SET_CAPACITY + 8;
   localparam int TIMEOUT_NS    = 2_000_000;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic signed [VALUE_W-1:0] set_contents[$];
   rsp_type                   awaited_rsps[$];
   int unsigned               mismatch_count = 0;
   bit                        sender_gaps    = 1'b1;
   bit                        receiver_gaps  = 1'b1;
   bit                        holdoff_req    = 1'b0;

   always #5 clock = ~clock;

   sorted_set_insert_delete #(.CAPACITY(SET_CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Applies one operation to the set copy and queues the results it causes.
   function automatic void apply_set_op(req_type op);
      logic signed [VALUE_W-1:0] v;
      logic [STATUS_W-1:0]       outcome;
      int unsigned               pos;
      rsp_type                   r;
      v       = op.value;
      outcome = ST_INSERTED;
      pos     = 0;
      while (pos < set_contents.size() && set_contents[pos] < v)
         pos++;
      if (op.kind == KIND_INSERT) begin
         if (pos < set_contents.size() && set_contents[pos] == v)
            outcome = ST_DUPLICATE;
         else if (set_contents.size() >= SET_CAPACITY)
            outcome = ST_FULL;
         else begin
            set_contents.insert(pos, v);
            foreach (set_contents[i]) begin
               r.status      = ST_INSERTED;
               r.has_entry   = 1'b1;
               r.entry_value = set_contents[i];
               r.last        = (i == set_contents.size() - 1);
               awaited_rsps.push_back(r);
            end
         end
      end else if (set_contents.size() == 0)
         outcome = ST_EMPTY;
      else if (pos >= set_contents.size() || set_contents[pos] != v)
         outcome = ST_NOT_FOUND;
      else begin
         set_contents.delete(pos);
         outcome = ST_DELETED;
      end
      if (outcome != ST_INSERTED) begin
         r.status      = outcome;
         r.has_entry   = 1'b0;
         r.entry_value = '0;
         r.last        = 1'b1;
         awaited_rsps.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0)
         apply_set_op(req_data);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_rsps.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result, actual status %0d has_entry %0b value %0d last %0b",
                     $time, rsp_data.status, rsp_data.has_entry,
                     $signed(rsp_data.entry_value), rsp_data.last);
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.has_entry !== want.has_entry ||
                rsp_data.entry_value !== want.entry_value || rsp_data.last !== want.last) begin
               mismatch_count++;
               $display("%0t: expected status %0d has_entry %0b value %0d last %0b",
                        $time, want.status, want.has_entry,
                        $signed(want.entry_value), want.last);
               $display("%0t:   actual status %0d has_entry %0b value %0d last %0b",
                        $time, rsp_data.status, rsp_data.has_entry,
                        $signed(rsp_data.entry_value), rsp_data.last);
            end
         end
      end
   end

   // Output side: random stalls, or a long hold-off when a test asks for one.
   initial begin : result_receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= receiver_gaps && ($urandom_range(99, 0) < 26);
      end
   end

   // valid is left high on return so back-to-back items need no lowering
   task automatic send_op(input logic kind, input logic signed [VALUE_W-1:0] value);
      while (sender_gaps && $urandom_range(99, 0) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, value: value};
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   // Mostly values already stored or near zero so duplicates and hits happen.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 40 && set_contents.size() != 0)
         return set_contents[$urandom_range(set_contents.size() - 1, 0)];
      if (roll < 65)
         return $signed($urandom_range(15, 0)) - 32'sd8;
      if (roll < 70)
         return $urandom_range(1, 0) ? VAL_MAX : VAL_MIN;
      return $urandom();
   endfunction

   task automatic test_edges_and_codes();
      send_op(KIND_DELETE, 32'sd5);            // store empty
      send_op(KIND_INSERT, 32'sd0);
      send_op(KIND_INSERT, 32'sd0);            // duplicate
      send_op(KIND_INSERT, VAL_MIN);
      send_op(KIND_INSERT, VAL_MAX);
      send_op(KIND_INSERT, -32'sd1);
      send_op(KIND_INSERT, 32'sd1);
      send_op(KIND_INSERT, 32'sh5555_5555);
      send_op(KIND_INSERT, 32'shAAAA_AAAA);
      send_op(KIND_INSERT, VAL_MAX);           // duplicate at the tail
      send_op(KIND_INSERT, VAL_MIN);           // duplicate at the head
      send_op(KIND_DELETE, 32'sd7);            // absent, between entries
      send_op(KIND_DELETE, VAL_MIN);           // head
      send_op(KIND_DELETE, VAL_MAX);           // tail
      send_op(KIND_DELETE, VAL_MAX);           // absent, above every entry
      send_op(KIND_DELETE, VAL_MIN);           // absent, below every entry
      send_op(KIND_DELETE, 32'sd0);            // middle
      send_op(KIND_DELETE, 32'sd0);
      send_op(KIND_DELETE, -32'sd1);
      send_op(KIND_DELETE, 32'sd1);
      send_op(KIND_DELETE, 32'sh5555_5555);
      send_op(KIND_DELETE, 32'shAAAA_AAAA);
      send_op(KIND_DELETE, VAL_MAX);           // empty again
      wait_until_drained();
   endtask

   task automatic test_fill_to_capacity();
      logic signed [VALUE_W-1:0] v;
      int                        n;
      // no idling on either side while the store fills
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      n = SET_CAPACITY - set_contents.size();
      repeat (n) send_op(KIND_INSERT, $urandom());
      wait_until_drained();
      // a random repeat above leaves a slot free
      while (set_contents.size() < SET_CAPACITY) begin
         send_op(KIND_INSERT, $urandom());
         wait_until_drained();
      end
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      send_op(KIND_INSERT, $urandom());                     // full
      send_op(KIND_INSERT, set_contents[0]);                // duplicate wins over full
      send_op(KIND_INSERT, set_contents[SET_CAPACITY - 1]);
      v = set_contents[$urandom_range(SET_CAPACITY - 1, 0)];
      send_op(KIND_DELETE, v);
      send_op(KIND_INSERT, v);                              // back to full, 32-entry dump
      send_op(KIND_INSERT, VAL_MIN);
      wait_until_drained();
      repeat (6)
         send_op(KIND_DELETE, set_contents[$urandom_range(set_contents.size() - 1, 0)]);
      wait_until_drained();
   endtask

   task automatic test_random_ops(input int count);
      for (int i = 0; i < count; i++) begin
         send_op(($urandom_range(99, 0) < 45) ? KIND_DELETE : KIND_INSERT, pick_value());
         if (i % 40 == 39)
            wait_until_drained();
      end
      wait_until_drained();
   endtask

   // rsp held off long enough that the block backs up onto req
   task automatic test_output_holdoff();
      holdoff_req = 1'b1;
      repeat (12)
         send_op($urandom_range(1, 0) ? KIND_DELETE : KIND_INSERT, pick_value());
      wait_until_drained();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_edges_and_codes();
      test_fill_to_capacity();
      test_random_ops(40);
      test_output_holdoff();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
